/* rtl/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and types for the pedestal/table correcting window framer.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Default geometry of the pedestal store and transfer table
    localparam int DEF_WINDOW_COUNT = 512;
    localparam int DEF_ROW_COUNT    = 16;
    localparam int DEF_COLUMN_COUNT = 32;
    localparam int DEF_TABLE_DEPTH  = 2048;

    // Stream widths (fixed by the item fields)
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int CFG_W     = 16;

    // Frame marker words
    localparam logic [15:0] HEADER_WORD  = 16'hAA55;
    localparam logic [15:0] TRAILER_WORD = 16'hCC33;

    // Result queue depth, power of two
    localparam int RES_FIFO_DEPTH = 8;

    // Operation codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_PED_LOAD = 2'd0,
        OP_TBL_LOAD = 2'd1,
        OP_HEADER   = 2'd2,
        OP_SAMPLE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [15:0] word;
        logic        error;
        logic        last;
    } result_t;

    // Up to two results written into the queue per cycle; res1 only with res0
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

/* rtl/pedestal_lut_correct_framer_unit.sv */
// ----------------------------------------------------------------------------
// pedestal_lut_correct_framer_unit
// Takes one item per clock while s_axis_tready is high. Loads fill the
// pedestal store (one 16-bit entry per window, row and column) and the
// transfer table; a header checks the window id and opens a frame (0xAA55,
// window number) or gives a single error result; each sample of an open
// frame reads its pedestal, forms raw + offset - pedestal (16-bit wrap),
// clamps it to the table's last entry and emits the table entry; after the
// last sample of a window the trailer 0xCC33 follows with tlast. Work runs
// in a three-stage pipeline: stage 1 accesses the pedestal store, stage 2
// the table, and stage 3 writes the results into an 8-entry queue whose
// head is shown on the master side. Results leave one per clock while
// m_axis_tready is high; a header and the last sample of a window each give
// two, so over a long run the output port sets the pace (one result per
// clock). s_axis_tready depends only on the queue fill and the items in the
// pipe, never combinationally on m_axis_tready. Both stores come up
// undefined and must be loaded before use; there is no clearing pass.
// ----------------------------------------------------------------------------
module pedestal_lut_correct_framer_unit
#(
    parameter int WINDOW_COUNT = plc_pkg::DEF_WINDOW_COUNT,
    parameter int ROW_COUNT    = plc_pkg::DEF_ROW_COUNT,
    parameter int COLUMN_COUNT = plc_pkg::DEF_COLUMN_COUNT,
    parameter int TABLE_DEPTH  = plc_pkg::DEF_TABLE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [17:0] load_address, [33:18] load_value, [42:34] expected_window,
    // [51:43] received_window_id, [67:52] raw_sample, [71:68] zero
    input  logic [plc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [plc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] word
    output logic [plc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] error
    output logic [plc_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast,
    // pedestal_offset write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [plc_pkg::CFG_W-1:0]      cfg_data
);

    localparam int WIN_SAMPLES = ROW_COUNT * COLUMN_COUNT;
    localparam int STORE_DEPTH = WINDOW_COUNT * WIN_SAMPLES;
    localparam int PED_AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int WIN_W       = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
    localparam int POS_W       = (WIN_SAMPLES > 1) ? $clog2(WIN_SAMPLES) : 1;
    localparam int CNT_W       = $clog2(plc_pkg::RES_FIFO_DEPTH+1);

    // What an item does once inside the pipe
    typedef enum logic [2:0] {
        K_NONE,
        K_PED_WR,
        K_TBL_WR,
        K_ERROR,
        K_HEADER,
        K_SAMPLE
    } kind_t;

    // Window number modulo WINDOW_COUNT by constant-shifted compare/subtract
    function automatic logic [WIN_W-1:0] window_mod(input logic [8:0] x);
        logic [9:0] r;
        r = {1'b0, x};
        for (int k = 9; k >= 0; k--)
        begin
            if ((WINDOW_COUNT << k) <= 511)
            begin
                if (r >= 10'(WINDOW_COUNT << k))
                begin
                    r = r - 10'(WINDOW_COUNT << k);
                end
            end
        end
        return r[WIN_W-1:0];
    endfunction

    // Results an item will push into the queue
    function automatic logic [1:0] res_count(input kind_t k, input logic last);
        logic [1:0] n;
        case (k)
            K_ERROR:  n = 2'd1;
            K_HEADER: n = 2'd2;
            K_SAMPLE: n = last ? 2'd2 : 2'd1;
            default:  n = 2'd0;
        endcase
        return n;
    endfunction

    // ---------------- input unpack ----------------
    plc_pkg::op_t in_op;
    logic [17:0] in_addr;
    logic [15:0] in_value;
    logic [8:0]  in_exp;
    logic [8:0]  in_rx;
    logic [15:0] in_raw;
    logic        accept;
    logic [31:0] addr_ext;

    assign in_op    = plc_pkg::op_t'(s_axis_tuser);
    assign in_addr  = s_axis_tdata[17:0];
    assign in_value = s_axis_tdata[33:18];
    assign in_exp   = s_axis_tdata[42:34];
    assign in_rx    = s_axis_tdata[51:43];
    assign in_raw   = s_axis_tdata[67:52];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign addr_ext = 32'(in_addr);

    // ---------------- configuration ----------------
    logic [15:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            offset_reg <= cfg_data;
        end
    end

    // ---------------- frame tracking (accept stage) ----------------
    logic             frame_active_reg;
    logic             frame_active_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [WIN_W-1:0] win_mod_reg;
    logic [WIN_W-1:0] win_mod_next;
    kind_t            kind0;
    logic             last0;
    logic [31:0]      samp_addr;
    logic [PED_AW-1:0] ped_addr0;

    // pedestal address of the next sample in the open window
    assign samp_addr = 32'(win_mod_reg) * 32'(WIN_SAMPLES) + 32'(pos_reg);
    assign ped_addr0 = (in_op == plc_pkg::OP_PED_LOAD) ? addr_ext[PED_AW-1:0]
                                                       : samp_addr[PED_AW-1:0];

    always_comb
    begin
        frame_active_next = frame_active_reg;
        pos_next          = pos_reg;
        win_mod_next      = win_mod_reg;
        kind0             = K_NONE;
        last0             = 1'b0;
        if (accept)
        begin
            unique case (in_op)
                plc_pkg::OP_PED_LOAD:
                begin
                    if (addr_ext < 32'(STORE_DEPTH))
                    begin
                        kind0 = K_PED_WR;
                    end
                end
                plc_pkg::OP_TBL_LOAD:
                begin
                    if (addr_ext < 32'(TABLE_DEPTH))
                    begin
                        kind0 = K_TBL_WR;
                    end
                end
                plc_pkg::OP_HEADER:
                begin
                    // a header drops any open frame without trailer
                    if (in_rx != in_exp)
                    begin
                        kind0             = K_ERROR;
                        frame_active_next = 1'b0;
                    end
                    else
                    begin
                        kind0             = K_HEADER;
                        frame_active_next = 1'b1;
                        pos_next          = '0;
                        win_mod_next      = window_mod(in_exp);
                    end
                end
                plc_pkg::OP_SAMPLE:
                begin
                    if (frame_active_reg)
                    begin
                        kind0 = K_SAMPLE;
                        if (32'(pos_reg) == 32'(WIN_SAMPLES - 1))
                        begin
                            last0             = 1'b1;
                            frame_active_next = 1'b0;
                            pos_next          = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            pos_reg          <= '0;
            win_mod_reg      <= '0;
        end
        else
        begin
            frame_active_reg <= frame_active_next;
            pos_reg          <= pos_next;
            win_mod_reg      <= win_mod_next;
        end
    end

    // ---------------- pipe stage 1: pedestal store access ----------------
    kind_t             s1_kind_reg;
    logic              s1_last_reg;
    logic [PED_AW-1:0] s1_ped_addr_reg;
    logic [TBL_AW-1:0] s1_tbl_addr_reg;
    logic [15:0]       s1_value_reg;
    logic [15:0]       s1_raw_reg;
    logic [8:0]        s1_win_reg;

    // ---------------- pipe stage 2: table access ----------------
    kind_t             s2_kind_reg;
    logic              s2_last_reg;
    logic [15:0]       s2_raw_reg;
    logic [8:0]        s2_win_reg;
    logic [15:0]       ped_rd_reg;

    // ---------------- pipe stage 3: queue write ----------------
    kind_t             s3_kind_reg;
    logic              s3_last_reg;
    logic [8:0]        s3_win_reg;
    logic [15:0]       tbl_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_kind_reg <= K_NONE;
            s2_kind_reg <= K_NONE;
            s3_kind_reg <= K_NONE;
        end
        else
        begin
            s1_kind_reg <= kind0;
            s2_kind_reg <= s1_kind_reg;
            s3_kind_reg <= s2_kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg     <= last0;
        s1_ped_addr_reg <= ped_addr0;
        s1_tbl_addr_reg <= addr_ext[TBL_AW-1:0];
        s1_value_reg    <= in_value;
        s1_raw_reg      <= in_raw;
        s1_win_reg      <= in_exp;
        s2_last_reg     <= s1_last_reg;
        s2_raw_reg      <= s1_raw_reg;
        s2_win_reg      <= s1_win_reg;
        s3_last_reg     <= s2_last_reg;
        s3_win_reg      <= s2_win_reg;
    end

    // Pedestal store: one access per cycle, write or read, in item order
    logic [15:0] ped_mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (s1_kind_reg == K_PED_WR)
        begin
            ped_mem[s1_ped_addr_reg] <= s1_value_reg;
        end
        if (s1_kind_reg == K_SAMPLE)
        begin
            ped_rd_reg <= ped_mem[s1_ped_addr_reg];
        end
    end

    // Corrected value and clamp to the table range
    logic [15:0]       diff;
    logic [TBL_AW-1:0] tbl_idx;

    assign diff = s2_raw_reg + offset_reg - ped_rd_reg;

    always_comb
    begin
        if (32'(diff) > 32'(TABLE_DEPTH - 1))
        begin
            tbl_idx = TBL_AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            tbl_idx = diff[TBL_AW-1:0];
        end
    end

    // Transfer table: a load in stage 1 writes while an older sample in
    // stage 2 reads; the read returns the old entry, which is item order.
    logic [15:0] tbl_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (s2_kind_reg == K_SAMPLE)
        begin
            tbl_rd_reg <= tbl_mem[tbl_idx];
        end
        if (s1_kind_reg == K_TBL_WR)
        begin
            tbl_mem[s1_tbl_addr_reg] <= s1_value_reg;
        end
    end

    // ---------------- result assembly ----------------
    plc_pkg::push_t   push;
    plc_pkg::result_t head;
    logic             fifo_not_empty;
    logic [CNT_W-1:0] fifo_count;
    logic             pop;

    always_comb
    begin
        push = '0;
        unique case (s3_kind_reg)
            K_ERROR:
            begin
                push.valid0     = 1'b1;
                push.res0.word  = '0;
                push.res0.error = 1'b1;
                push.res0.last  = 1'b1;
            end
            K_HEADER:
            begin
                push.valid0    = 1'b1;
                push.res0.word = plc_pkg::HEADER_WORD;
                push.valid1    = 1'b1;
                push.res1.word = 16'(s3_win_reg);
            end
            K_SAMPLE:
            begin
                push.valid0    = 1'b1;
                push.res0.word = tbl_rd_reg;
                if (s3_last_reg)
                begin
                    push.valid1    = 1'b1;
                    push.res1.word = plc_pkg::TRAILER_WORD;
                    push.res1.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    plc_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (fifo_not_empty),
        .count     (fifo_count)
    );

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = fifo_not_empty;
    assign m_axis_tdata  = head.word;
    assign m_axis_tuser  = head.error;
    assign m_axis_tlast  = head.last;

    // Space booked: queue fill plus everything still in the pipe; a new
    // item may need two slots.
    logic [7:0] booked;

    assign booked = 8'(fifo_count)
                  + 8'(res_count(s1_kind_reg, s1_last_reg))
                  + 8'(res_count(s2_kind_reg, s2_last_reg))
                  + 8'(res_count(s3_kind_reg, s3_last_reg));

    assign s_axis_tready = (booked <= 8'(plc_pkg::RES_FIFO_DEPTH - 2));

endmodule

/* rtl/plc_result_fifo.sv */
// ----------------------------------------------------------------------------
// plc_result_fifo
// Small result queue: two writes and one read per cycle, head shown directly.
// ----------------------------------------------------------------------------
module plc_result_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  plc_pkg::push_t   push,
    input  logic             pop,
    output plc_pkg::result_t head,
    output logic             not_empty,
    output logic [$clog2(plc_pkg::RES_FIFO_DEPTH+1)-1:0] count
);

    localparam int DEPTH = plc_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    plc_pkg::result_t fifo_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       push_num;

    assign push_num    = {1'b0, push.valid0} + {1'b0, push.valid1};
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_num);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_num) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            fifo_mem[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= push.res1;
        end
    end

    assign head      = fifo_mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

/* rtl/plc_checker.sv */
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks on the framer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [plc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [plc_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                          m_axis_tlast
);

    // rejected window: zero word, always ends the frame
    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("error item without tlast or with nonzero word");

    // a non-error frame end is always the trailer word
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0])
            |-> (m_axis_tdata == plc_pkg::TRAILER_WORD))
        else $error("tlast on a word other than the trailer");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
        else $error("master item changed while stalled");

endmodule

bind pedestal_lut_correct_framer_unit plc_checker u_plc_checker (.*);

/* bench/pedestal_lut_correct_framer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedestal_lut_correct_framer_unit_tb
// Self-checking bench for the window framer. A scoreboard class keeps its
// own copy of the pedestal store, the transfer table, the frame state and
// the offset register, predicts the results of each accepted item and
// checks the master side in order. Stimulus is a short directed part
// followed by random frames. Pedestal and table entries that a sample reads
// get loaded just before it when unloaded. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module pedestal_lut_correct_framer_unit_tb;

    localparam int WINDOW_COUNT  = plc_pkg::DEF_WINDOW_COUNT;
    localparam int TABLE_DEPTH   = plc_pkg::DEF_TABLE_DEPTH;
    localparam int WIN_SAMPLES   = plc_pkg::DEF_ROW_COUNT * plc_pkg::DEF_COLUMN_COUNT;
    localparam int STORE_DEPTH   = WINDOW_COUNT * WIN_SAMPLES;
    localparam int CLAMP_MAX     = TABLE_DEPTH - 1;
    localparam int RANDOM_ITEMS  = 750;
    localparam int DRAIN_CYCLES  = 8;   // pipe is three stages deep, allow some slack
    localparam int TIMEOUT_NS    = 5_000_000;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: frame predictor plus in-order result check
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [15:0] pedestal [STORE_DEPTH];
        bit          ped_loaded [STORE_DEPTH];
        logic [15:0] lut [TABLE_DEPTH];
        bit          lut_loaded [TABLE_DEPTH];
        logic [8:0]  window;
        int unsigned position;
        bit          frame_open;
        logic [15:0] offset;
        plc_pkg::result_t expected_results [$];
        int          mismatches;
        int          trailers;

        function new();
            window     = '0;
            position   = 0;
            frame_open = 1'b0;
            offset     = '0;
            mismatches = 0;
            trailers   = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // pedestal entry for the next sample of the open frame
        function int unsigned ped_addr();
            return (int'(window) % WINDOW_COUNT) * WIN_SAMPLES + position;
        endfunction

        // raw + offset - pedestal, 16-bit wrap, clamped to the last table entry
        function logic [15:0] table_index(logic [15:0] raw);
            logic [15:0] diff;
            diff = raw + offset - pedestal[ped_addr()];
            return (diff > 16'(CLAMP_MAX)) ? 16'(CLAMP_MAX) : diff;
        endfunction

        function void push_result(logic [15:0] word, logic error, logic last);
            plc_pkg::result_t r;
            r.word  = word;
            r.error = error;
            r.last  = last;
            expected_results.push_back(r);
        endfunction

        // returns 1 when the item had any effect on the block
        function int note_input(plc_pkg::op_t op, logic [17:0] addr, logic [15:0] val,
                                logic [8:0] expw, logic [8:0] rxid, logic [15:0] raw);
            logic [15:0] idx;
            case (op)
                plc_pkg::OP_PED_LOAD:
                begin
                    if (int'(addr) >= STORE_DEPTH)
                        return 0;
                    pedestal[addr]   = val;
                    ped_loaded[addr] = 1'b1;
                    return 1;
                end
                plc_pkg::OP_TBL_LOAD:
                begin
                    if (int'(addr) >= TABLE_DEPTH)
                        return 0;
                    lut[addr]        = val;
                    lut_loaded[addr] = 1'b1;
                    return 1;
                end
                plc_pkg::OP_HEADER:
                begin
                    if (rxid != expw)
                    begin
                        frame_open = 1'b0;
                        push_result(16'h0000, 1'b1, 1'b1);
                    end
                    else
                    begin
                        // an open frame is simply dropped, no trailer
                        window     = expw;
                        position   = 0;
                        frame_open = 1'b1;
                        push_result(plc_pkg::HEADER_WORD, 1'b0, 1'b0);
                        push_result({7'd0, expw}, 1'b0, 1'b0);
                    end
                    return 1;
                end
                default:
                begin
                    if (!frame_open)
                        return 0;
                    idx = table_index(raw);
                    push_result(lut[idx], 1'b0, 1'b0);
                    position++;
                    if (position >= WIN_SAMPLES)
                    begin
                        push_result(plc_pkg::TRAILER_WORD, 1'b0, 1'b1);
                        frame_open = 1'b0;
                        position   = 0;
                        trailers++;
                    end
                    return 1;
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(plc_pkg::result_t got);
            plc_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result word=%h error=%b last=%b",
                                          got.word, got.error, got.last));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.word !== want.word || got.error !== want.error
                    || got.last !== want.last)
                    report_mismatch($sformatf(
                        "word=%h error=%b last=%b, want word=%h error=%b last=%b",
                        got.word, got.error, got.last, want.word, want.error, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [17:0] load_address, [33:18] load_value, [42:34] expected_window,
    // [51:43] received_window_id, [67:52] raw_sample, [71:68] zero
    logic [plc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // [1:0] operation
    logic [plc_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] word
    logic [plc_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // [0] error
    logic [plc_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [plc_pkg::CFG_W-1:0] cfg_data = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pedestal_lut_correct_framer_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    frame_scoreboard sb = new();

    int          burst_left = 0;   // items left in the current sender burst
    int          counted = 0;      // effective items in the random part
    logic [8:0]  window_pool [3];  // windows that get full frames

    // ------------------------------------------------------------------------
    // Receiver: back-pressure pattern switches at random among four modes
    // ------------------------------------------------------------------------
    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned mode_left = 0;
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(64, 512);
        end
        else
            mode_left <= mode_left - 1;
        cycle_count <= cycle_count + 1;
        case (ready_mode)
            READY_ALWAYS:   m_axis_tready <= 1'b1;
            READY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: m_axis_tready <= (cycle_count % 5) != 0;
            default:        m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Outputs are sampled mid-cycle: the handshake seen at the falling edge
    // is the one that completes at the next rising edge.
    always @(negedge clk)
    begin
        plc_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.word  = m_axis_tdata;
            got.error = m_axis_tuser[0];
            got.last  = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // One item on the slave side; bursts of random length with random gaps.
    task automatic send_item(plc_pkg::op_t op, logic [17:0] addr, logic [15:0] val,
                             logic [8:0] expw, logic [8:0] rxid, logic [15:0] raw);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, raw, rxid, expw, val, addr};
        s_axis_tuser  <= op;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        if (sb.note_input(op, addr, val, expw, rxid, raw) != 0)
            counted++;
    endtask

    task automatic send_header(logic [8:0] expw, logic [8:0] rxid);
        send_item(plc_pkg::OP_HEADER, 18'($urandom), 16'($urandom), expw, rxid,
                  16'($urandom));
    endtask

    // One sample. With by_target set, raw is chosen so that the corrected
    // difference equals value; otherwise value is the raw sample itself.
    // Unloaded pedestal and table entries that it reads are loaded first.
    task automatic send_sample(bit by_target, logic [15:0] value);
        int unsigned paddr;
        logic [15:0] raw;
        logic [15:0] idx;
        raw = value;
        if (sb.frame_open)
        begin
            paddr = sb.ped_addr();
            if (!sb.ped_loaded[paddr])
                send_item(plc_pkg::OP_PED_LOAD, 18'(paddr), 16'($urandom), 9'($urandom),
                          9'($urandom), 16'($urandom));
            if (by_target)
                raw = value + sb.pedestal[paddr] - sb.offset;
            idx = sb.table_index(raw);
            if (!sb.lut_loaded[idx])
                send_item(plc_pkg::OP_TBL_LOAD, 18'(idx), 16'($urandom), 9'($urandom),
                          9'($urandom), 16'($urandom));
        end
        send_item(plc_pkg::OP_SAMPLE, 18'($urandom), 16'($urandom), 9'($urandom),
                  9'($urandom), raw);
    endtask

    // Offset register write, only with the block drained. Loads give no
    // result, so a wait of DRAIN_CYCLES lets the last of them leave the pipe.
    task automatic write_offset(logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.offset = value;
    endtask

    // One random frame: header (sometimes with a wrong id), then samples.
    // Pool windows mostly get a full frame ending in the trailer; other
    // windows get short frames that the next header cuts off.
    task automatic run_frame();
        logic [8:0]  win;
        logic [8:0]  rxid;
        int unsigned n;
        bit          full;
        full = $urandom_range(0, 2) != 0;
        win  = full ? window_pool[$urandom_range(0, 2)] : 9'($urandom);
        rxid = win;
        if ($urandom_range(0, 7) == 0)
            rxid = win ^ 9'($urandom_range(1, 511));
        send_header(win, rxid);
        n = (full && rxid == win) ? WIN_SAMPLES : $urandom_range(0, 40);
        for (int i = 0; i < n; i++)
        begin
            // stray loads: random pedestal addresses, table loads mostly
            // out of range
            if ($urandom_range(0, 15) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(plc_pkg::OP_PED_LOAD, 18'($urandom), 16'($urandom),
                              9'($urandom), 9'($urandom), 16'($urandom));
                else
                    send_item(plc_pkg::OP_TBL_LOAD, 18'($urandom), 16'($urandom),
                              9'($urandom), 9'($urandom), 16'($urandom));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_sample(1'b1, 16'($urandom_range(0, CLAMP_MAX)));
                5:             send_sample(1'b1,
                                           16'($urandom_range(CLAMP_MAX - 8, CLAMP_MAX + 8)));
                6:             send_sample(1'b1, 16'($urandom_range(65520, 65535)));
                default:       send_sample(1'b0, 16'($urandom));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] next_offset;
        window_pool[0] = 9'd0;
        window_pool[1] = 9'd511;
        window_pool[2] = 9'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_offset(16'h0000);

        // table edges, then loads past the table end that must not alias
        send_item(plc_pkg::OP_TBL_LOAD, 18'd0, 16'h0000, 9'd0, 9'd0, 16'd0);
        send_item(plc_pkg::OP_TBL_LOAD, 18'(CLAMP_MAX), 16'hFFFF, 9'd0, 9'd0, 16'd0);
        send_item(plc_pkg::OP_TBL_LOAD, 18'(TABLE_DEPTH), 16'h5A5A, 9'd0, 9'd0, 16'd0);
        send_item(plc_pkg::OP_TBL_LOAD, 18'h3FFFF, 16'hA5A5, 9'd0, 9'd0, 16'd0);
        // pedestal store edges
        send_item(plc_pkg::OP_PED_LOAD, 18'd0, 16'h0000, 9'd0, 9'd0, 16'd0);
        send_item(plc_pkg::OP_PED_LOAD, 18'(STORE_DEPTH - 1), 16'hFFFF, 9'h1FF, 9'h1FF,
                  16'hFFFF);
        // sample with no frame open: ignored
        send_sample(1'b0, 16'hFFFF);
        // id mismatch gives the error item
        send_header(9'd0, 9'd511);
        // good header on the top window, then difference edges:
        // zero, last entry, one past it, underflow, raw extremes
        send_header(9'd511, 9'd511);
        send_sample(1'b1, 16'd0);
        send_sample(1'b1, 16'(CLAMP_MAX));
        send_sample(1'b1, 16'(TABLE_DEPTH));
        send_sample(1'b1, 16'hFFFF);
        send_sample(1'b0, 16'h0000);
        send_sample(1'b0, 16'hFFFF);
        // new header over an open frame drops it without a trailer
        send_header(9'd0, 9'd0);
        send_sample(1'b1, 16'd0);
        send_sample(1'b0, 16'h8000);
        // mismatch while a frame is open closes it; next sample ignored
        send_header(9'd5, 9'd6);
        send_sample(1'b0, 16'h1234);

        // top offset value 0xFFFF: raw 0xFFFF plus the offset wraps at 16 bits
        write_offset(16'hFFFF);
        send_header(9'd0, 9'd0);
        send_sample(1'b1, 16'(CLAMP_MAX));
        send_sample(1'b0, 16'h0000);
        send_sample(1'b0, 16'hFFFF);

        // random frames, with offset changes between some of them
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            run_frame();
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       next_offset = 16'h0000;
                    1:       next_offset = 16'hFFFF;
                    2:       next_offset = 16'($urandom_range(0, CLAMP_MAX));
                    default: next_offset = 16'($urandom);
                endcase
                write_offset(next_offset);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop in case the block hangs
    initial
    begin
        #TIMEOUT_NS;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
